// File: rtl/core/lsac_pkg.sv
// Shared types and constants for the LRU set-associative cache core.
// Holds the request/result payloads, the stored line format and the register indexes.
// No dependencies.
package lsac_pkg;

	// fixed field widths
	localparam int ADDR_W  = 32;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;

	// default geometry of the built store
	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS     = 8;

	// configuration port
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 5;
	localparam int SET_BITS_W     = 3;
	localparam int WAYS_W         = 4;
	localparam int BLOCK_BITS_W   = 5;

	localparam logic [SET_BITS_W-1:0]   RST_SET_BITS   = 3'd4;
	localparam logic [WAYS_W-1:0]       RST_WAYS       = 4'd1;
	localparam logic [BLOCK_BITS_W-1:0] RST_BLOCK_BITS = 5'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS    = 2'd0,
		CFG_WAYS_IN_USE = 2'd1,
		CFG_BLOCK_BITS  = 2'd2
	} lsac_cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_STORE  = 2'd1,
		MODE_MODIFY = 2'd2
	} lsac_mode_t;

	// one access request
	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [1:0]        mode;
	} lsac_req_t;

	// one access result
	typedef struct packed {
		logic             hit;
		logic             miss;
		logic             evict;
		logic             extra_hit;
		logic [CNT_W-1:0] total_hits;
		logic [CNT_W-1:0] total_misses;
		logic [CNT_W-1:0] total_evictions;
	} lsac_res_t;

	// one stored cache line
	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  tag;
		logic [STAMP_W-1:0] stamp;
	} lsac_line_t;

	// lookup outcome handed back to the control
	typedef struct packed {
		logic hit;
		logic evict;
	} lsac_look_t;

endpackage

// File: rtl/core/lsac_set_ram.sv
// Set store: one row per set holding every way's line, synchronous read.
// Depends on lsac_pkg for the line format.
module lsac_set_ram import lsac_pkg::*; #(
	parameter int SET_W    = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS = DEF_MAX_WAYS
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [SET_W-1:0]             waddr,
	input  lsac_line_t [MAX_WAYS-1:0]    wdata,
	input  logic [SET_W-1:0]             raddr,
	output lsac_line_t [MAX_WAYS-1:0]    rdata
);

	localparam int DEPTH = 1 << SET_W;

	lsac_line_t [MAX_WAYS-1:0] mem [DEPTH];
	lsac_line_t [MAX_WAYS-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/lsac_lookup.sv
// Tag compare and replacement choice over one set row; builds the row to write back.
// Depends on lsac_pkg for the line format and status struct.
module lsac_lookup import lsac_pkg::*; #(
	parameter  int MAX_WAYS  = DEF_MAX_WAYS,
	localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
	localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1)
) (
	input  lsac_line_t [MAX_WAYS-1:0] row_in,
	input  logic [ADDR_W-1:0]         tag,
	input  logic [WAY_CNT_W-1:0]      ways_eff,
	input  logic [STAMP_W-1:0]        stamp_now,
	output lsac_line_t [MAX_WAYS-1:0] row_out,
	output lsac_look_t                status
);

	localparam int LEAVES = 1 << WAY_IDX_W;
	localparam int NODES  = 2 * LEAVES - 1;

	logic [MAX_WAYS-1:0]  enabled;
	logic [MAX_WAYS-1:0]  match;
	logic [MAX_WAYS-1:0]  empty;
	logic [WAY_IDX_W-1:0] hit_idx;
	logic [WAY_IDX_W-1:0] empty_idx;
	logic [WAY_IDX_W-1:0] victim;
	logic [STAMP_W:0]     key [NODES];
	logic [WAY_IDX_W-1:0] idx [NODES];

	// per-way flags
	always_comb begin
		for (int k = 0; k < MAX_WAYS; k++) begin
			enabled[k] = (WAY_CNT_W'(k) < ways_eff);
			match[k]   = enabled[k] & row_in[k].valid & (row_in[k].tag == tag);
			empty[k]   = enabled[k] & ~row_in[k].valid;
		end
	end

	// lowest matching way and lowest empty way
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int k = MAX_WAYS - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit_idx = WAY_IDX_W'(k);
			end
			if (empty[k]) begin
				empty_idx = WAY_IDX_W'(k);
			end
		end
	end

	// oldest stamp by a compare tree; disabled ways carry a high key bit,
	// left child wins on ties so the lowest way is taken
	always_comb begin
		for (int k = 0; k < LEAVES; k++) begin
			key[LEAVES-1+k] = '1;
			idx[LEAVES-1+k] = WAY_IDX_W'(k);
		end
		for (int k = 0; k < MAX_WAYS; k++) begin
			key[LEAVES-1+k] = {~enabled[k], row_in[k].stamp};
		end
		for (int n = LEAVES - 2; n >= 0; n--) begin
			if (key[2*n+2] < key[2*n+1]) begin
				key[n] = key[2*n+2];
				idx[n] = idx[2*n+2];
			end else begin
				key[n] = key[2*n+1];
				idx[n] = idx[2*n+1];
			end
		end
	end

	// updated row
	always_comb begin
		victim  = (|empty) ? empty_idx : idx[0];
		row_out = row_in;
		if (|match) begin
			row_out[hit_idx].stamp = stamp_now;
		end else begin
			row_out[victim].valid = 1'b1;
			row_out[victim].tag   = tag;
			row_out[victim].stamp = stamp_now;
		end
		status.hit   = |match;
		status.evict = ~(|match) & ~(|empty);
	end

endmodule

// File: rtl/core/lru_set_associative_cache_sim_core.sv
// LRU set-associative cache core: one request at a time, held off by busy.
// Path: request and set row are registered, then the row is written back, the result
// registered and done strobed; a new request can be taken while done shows.
// Reset: arst_n clears control state, then a clearing pass over all 2^MAX_SET_BITS
// set rows (64 by default) writes every set row invalid with busy held high.
module lru_set_associative_cache_sim_core import lsac_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  lsac_req_t             request,
	output logic                  busy,
	output logic                  done,
	output lsac_res_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SET_W     = MAX_SET_BITS;
	localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
	localparam int SB_W      = ($clog2(MAX_SET_BITS + 1) > SET_BITS_W) ?
	                           $clog2(MAX_SET_BITS + 1) : SET_BITS_W;
	localparam int SH_W      = $clog2((1 << BLOCK_BITS_W) + MAX_SET_BITS);

	// configuration registers
	logic [SET_BITS_W-1:0]   set_bits_q;
	logic [WAYS_W-1:0]       ways_q;
	logic [BLOCK_BITS_W-1:0] block_bits_q;

	// control
	logic             clr_q;
	logic [SET_W-1:0] clr_idx_q;
	logic             valid_s1;
	logic             accept;

	// request held while its set row is read
	logic [ADDR_W-1:0] tag_s1;
	logic [SET_W-1:0]  set_s1;
	logic              extra_s1;

	// address split
	logic [SB_W-1:0]      s_eff;
	logic [SH_W-1:0]      tag_shift;
	logic [ADDR_W-1:0]    addr_shift;
	logic [SET_W-1:0]     set_mask;
	logic [SET_W-1:0]     rd_set;
	logic [ADDR_W-1:0]    req_tag;
	logic [WAY_CNT_W-1:0] ways_eff;

	// store and lookup
	lsac_line_t [MAX_WAYS-1:0] row_rd;
	lsac_line_t [MAX_WAYS-1:0] row_new;
	lsac_line_t [MAX_WAYS-1:0] ram_wdata;
	logic                      ram_we;
	logic [SET_W-1:0]          ram_waddr;
	lsac_look_t                look;

	// totals
	logic [STAMP_W-1:0] clock_q;
	logic [STAMP_W-1:0] stamp_now;
	logic [CNT_W-1:0]   hits_q;
	logic [CNT_W-1:0]   misses_q;
	logic [CNT_W-1:0]   evicts_q;
	logic [1:0]         hit_inc;
	logic [CNT_W:0]     hit_sum;
	logic [CNT_W-1:0]   hits_nx;
	logic [CNT_W-1:0]   misses_nx;
	logic [CNT_W-1:0]   evicts_nx;
	lsac_res_t          result_q;
	logic               done_q;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

	assign busy   = clr_q | valid_s1;
	assign accept = start & ~busy;

	// geometry clamping and address split
	always_comb begin
		s_eff      = (SB_W'(set_bits_q) > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
		                                                       : SB_W'(set_bits_q);
		tag_shift  = SH_W'(block_bits_q) + SH_W'(s_eff);
		addr_shift = request.address >> block_bits_q;
		set_mask   = ~({SET_W{1'b1}} << set_bits_q);
		rd_set     = addr_shift[SET_W-1:0] & set_mask;
		req_tag    = request.address >> tag_shift;
		if (ways_q == '0) begin
			ways_eff = WAY_CNT_W'(1);
		end else if (int'(ways_q) > MAX_WAYS) begin
			ways_eff = WAY_CNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WAY_CNT_W'(ways_q);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= RST_SET_BITS;
			ways_q       <= RST_WAYS;
			block_bits_q <= RST_BLOCK_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SET_BITS:    set_bits_q   <= cfg_data[SET_BITS_W-1:0];
				CFG_WAYS_IN_USE: ways_q       <= cfg_data[WAYS_W-1:0];
				CFG_BLOCK_BITS:  block_bits_q <= cfg_data[BLOCK_BITS_W-1:0];
				default: ;
			endcase
		end
	end

	// clearing pass after reset, then request sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (&clr_idx_q) begin
					clr_q <= 1'b0;
				end
			end
			valid_s1 <= accept;
		end
	end

	// request fields held for the lookup cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1   <= req_tag;
			set_s1   <= rd_set;
			extra_s1 <= (request.mode == MODE_MODIFY);
		end
	end

	// write port: clearing rows or the updated set
	always_comb begin
		ram_we    = clr_q | valid_s1;
		ram_waddr = clr_q ? clr_idx_q : set_s1;
		ram_wdata = clr_q ? '0 : row_new;
	end

	lsac_set_ram #(
		.SET_W    (SET_W),
		.MAX_WAYS (MAX_WAYS)
	) u_set_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_set),
		.rdata (row_rd)
	);

	lsac_lookup #(
		.MAX_WAYS (MAX_WAYS)
	) u_lookup (
		.row_in    (row_rd),
		.tag       (tag_s1),
		.ways_eff  (ways_eff),
		.stamp_now (stamp_now),
		.row_out   (row_new),
		.status    (look)
	);

	// saturating totals
	always_comb begin
		stamp_now = clock_q + 1'b1;
		hit_inc   = {1'b0, look.hit} + {1'b0, extra_s1};
		hit_sum   = {1'b0, hits_q} + (CNT_W+1)'(hit_inc);
		hits_nx   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
		misses_nx = look.hit ? misses_q : sat_inc(misses_q);
		evicts_nx = look.evict ? sat_inc(evicts_q) : evicts_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q  <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				clock_q  <= stamp_now;
				hits_q   <= hits_nx;
				misses_q <= misses_nx;
				evicts_q <= evicts_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.hit             <= look.hit;
			result_q.miss            <= ~look.hit;
			result_q.evict           <= look.evict;
			result_q.extra_hit       <= extra_s1;
			result_q.total_hits      <= hits_nx;
			result_q.total_misses    <= misses_nx;
			result_q.total_evictions <= evicts_nx;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: rtl/core/lsac_checker.sv
// Port-level checks for the LRU set-associative cache core, bound to the top level.
// Depends on lsac_pkg for the result payload type.
module lsac_checker import lsac_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input lsac_res_t result
);

	// an accepted request locks out the next one
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after an accepted request");

	// every accepted request delivers a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result not delivered two cycles after accept");

	// results never come back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	// hit and miss exclusive, no eviction on a hit
	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.hit != result.miss) && !(result.hit && result.evict)))
		else $error("inconsistent hit, miss and evict flags");

endmodule

bind lru_set_associative_cache_sim_core lsac_checker u_lsac_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_set_associative_cache_sim_core.
// Needs lsac_pkg and the core. A directed table comes first, then random requests under
// several geometries, checked by a cycle-free LRU cache model, typed rows by the table.
module testbench;
	import lsac_pkg::*;

	localparam int NUM_SETS      = 1 << DEF_MAX_SET_BITS;
	localparam int NUM_LINES     = NUM_SETS * DEF_MAX_WAYS;
	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 255;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_GAP       = 20;
	localparam int CYCLE_LIMIT   = 400000;

	// one row of the directed table: either a register write or a request
	typedef struct {
		bit                    is_cfg;
		lsac_cfg_idx_t         idx;
		logic [CFG_DATA_W-1:0] val;
		lsac_req_t             req;
		bit                    typed;
		lsac_res_t             want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	lsac_req_t             request;
	logic                  busy;
	logic                  done;
	lsac_res_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// cache model state
	bit                  line_live [NUM_LINES];
	logic [ADDR_W-1:0]   line_tag_q [NUM_LINES];
	logic [STAMP_W-1:0]  line_age [NUM_LINES];
	logic [STAMP_W-1:0]  tick;
	logic [CNT_W-1:0]    hits_q;
	logic [CNT_W-1:0]    misses_q;
	logic [CNT_W-1:0]    evicts_q;
	logic [SET_BITS_W-1:0]   geo_set;
	logic [WAYS_W-1:0]       geo_ways;
	logic [BLOCK_BITS_W-1:0] geo_block;

	lsac_res_t outcomes_due [$];
	lsac_res_t want;
	plan_row_t plan [$];

	int errors;
	int requests_sent;
	int directed_count;
	int reg_writes;
	int seen_hits;
	int seen_misses;
	int seen_evicts;
	int cycles;

	int ph_set   [NUM_PHASES] = '{2, 6, 0, 7, 3, 1};
	int ph_ways  [NUM_PHASES] = '{4, 8, 2, 15, 0, 3};
	int ph_block [NUM_PHASES] = '{5, 0, 26, 3, 31, 12};

	lru_set_associative_cache_sim_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// effective geometry, clamped to the built store
	function automatic int used_set_bits();
		return (geo_set > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(geo_set);
	endfunction

	function automatic int used_ways();
		if (geo_ways == 0)
			return 1;
		return (geo_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(geo_ways);
	endfunction

	function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	// look the request up in the modelled cache and update it
	function automatic lsac_res_t access_line(lsac_req_t req);
		int s, w, b, base, way_empty, victim, k;
		logic [63:0] addr64, set_idx, tag64;
		logic [ADDR_W-1:0] tag;
		bit found;
		lsac_res_t r;
		s = used_set_bits();
		w = used_ways();
		b = int'(geo_block);
		addr64 = {32'd0, req.address};
		set_idx = (addr64 >> b) & ((64'd1 << s) - 64'd1) & 64'(NUM_SETS - 1);
		tag64 = addr64 >> (b + s);
		tag = (b + s >= ADDR_W) ? '0 : tag64[ADDR_W-1:0];
		base = int'(set_idx) * DEF_MAX_WAYS;
		tick = tick + 1'b1;
		found = 1'b0;
		way_empty = -1;
		victim = 0;
		r = '0;
		for (k = 0; k < w && !found; k++) begin
			if (line_live[base + k]) begin
				if (line_tag_q[base + k] == tag) begin
					found = 1'b1;
					line_age[base + k] = tick;
				end
			end else if (way_empty < 0) begin
				way_empty = k;
			end
		end
		r.hit = found;
		r.miss = !found;
		if (found) begin
			hits_q = sat_bump(hits_q);
		end else begin
			misses_q = sat_bump(misses_q);
			if (way_empty >= 0) begin
				victim = way_empty;
			end else begin
				// oldest stamp goes, ties to the lowest way
				for (k = 1; k < w; k++)
					if (line_age[base + k] < line_age[base + victim])
						victim = k;
				r.evict = 1'b1;
				evicts_q = sat_bump(evicts_q);
			end
			line_live[base + victim] = 1'b1;
			line_tag_q[base + victim] = tag;
			line_age[base + victim] = tick;
		end
		// write half of a modify always hits
		if (req.mode == MODE_MODIFY) begin
			r.extra_hit = 1'b1;
			hits_q = sat_bump(hits_q);
		end
		r.total_hits = hits_q;
		r.total_misses = misses_q;
		r.total_evictions = evicts_q;
		return r;
	endfunction

	// random address aimed at a few sets and a few tags more than the ways
	function automatic logic [ADDR_W-1:0] make_address();
		int s, w, b;
		logic [63:0] a, set_sel, tag_sel, offs;
		s = used_set_bits();
		w = used_ways();
		b = int'(geo_block);
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		set_sel = 64'($urandom_range(0, 3)) & ((64'd1 << s) - 64'd1);
		tag_sel = 64'($urandom_range(0, w + 2));
		offs = 64'($urandom) & ((64'd1 << b) - 64'd1);
		a = (tag_sel << (b + s)) | (set_sel << b) | offs;
		return a[ADDR_W-1:0];
	endfunction

	function automatic lsac_res_t outcome(bit h, bit m, bit e, bit x, int th, int tm, int te);
		lsac_res_t r;
		r.hit = h;
		r.miss = m;
		r.evict = e;
		r.extra_hit = x;
		r.total_hits = th;
		r.total_misses = tm;
		r.total_evictions = te;
		return r;
	endfunction

	function automatic plan_row_t access_row(logic [ADDR_W-1:0] addr, logic [1:0] mode,
			bit typed = 1'b0, lsac_res_t res = '0);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.idx = CFG_SET_BITS;
		r.val = '0;
		r.req.address = addr;
		r.req.mode = mode;
		r.typed = typed;
		r.want = res;
		return r;
	endfunction

	function automatic plan_row_t config_row(lsac_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		plan_row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		r.req = '0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// one register write, with the enable dropped again before the task returns
	task automatic cfg_write(lsac_cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_SET_BITS:    geo_set = val[SET_BITS_W-1:0];
			CFG_WAYS_IN_USE: geo_ways = val[WAYS_W-1:0];
			CFG_BLOCK_BITS:  geo_block = val[BLOCK_BITS_W-1:0];
			default: ;
		endcase
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// present a request, wait for it to be taken, record its outcome
	task automatic issue(lsac_req_t req, bit hold, bit typed, lsac_res_t typed_res);
		lsac_res_t r;
		start <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = access_line(req);
		outcomes_due.push_back(typed ? typed_res : r);
		requests_sent++;
		if (!hold)
			start <= 1'b0;
	endtask

	// wait until the core has nothing outstanding
	task automatic settle();
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (outcomes_due.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding, expected none, got %h",
					$time, result);
			end else begin
				want = outcomes_due.pop_front();
				check_field("hit", 32'(want.hit), 32'(result.hit));
				check_field("miss", 32'(want.miss), 32'(result.miss));
				check_field("evict", 32'(want.evict), 32'(result.evict));
				check_field("extra_hit", 32'(want.extra_hit), 32'(result.extra_hit));
				check_field("total_hits", want.total_hits, result.total_hits);
				check_field("total_misses", want.total_misses, result.total_misses);
				check_field("total_evictions", want.total_evictions, result.total_evictions);
			end
			if (result.hit === 1'b1)
				seen_hits++;
			if (result.miss === 1'b1)
				seen_misses++;
			if (result.evict === 1'b1)
				seen_evicts++;
		end
	end

	// stimulus
	initial begin
		lsac_req_t req;
		int i, p, n, gap, idle_pct;
		bit pause;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		requests_sent = 0;
		reg_writes = 0;
		seen_hits = 0;
		seen_misses = 0;
		seen_evicts = 0;
		geo_set = RST_SET_BITS;
		geo_ways = RST_WAYS;
		geo_block = RST_BLOCK_BITS;
		tick = '0;
		hits_q = '0;
		misses_q = '0;
		evicts_q = '0;
		for (i = 0; i < NUM_LINES; i++) begin
			line_live[i] = 1'b0;
			line_tag_q[i] = '0;
			line_age[i] = '0;
		end

		// reset geometry: 16 sets, one way, 16-byte blocks
		plan.push_back(access_row(32'h0000_0000, MODE_LOAD, 1'b1, outcome(0, 1, 0, 0, 0, 1, 0)));
		plan.push_back(access_row(32'h0000_000F, MODE_LOAD, 1'b1, outcome(1, 0, 0, 0, 1, 1, 0)));
		plan.push_back(access_row(32'h0000_0004, MODE_MODIFY, 1'b1, outcome(1, 0, 0, 1, 3, 1, 0)));
		plan.push_back(access_row(32'h0000_0100, MODE_STORE, 1'b1, outcome(0, 1, 1, 0, 3, 2, 1)));
		// reserved mode behaves as a load
		plan.push_back(access_row(32'hFFFF_FFFF, MODE_RESERVED, 1'b1, outcome(0, 1, 0, 0, 3, 3, 1)));
		plan.push_back(access_row(32'h0000_0000, MODE_MODIFY, 1'b1, outcome(0, 1, 1, 1, 4, 4, 2)));
		// full associativity, set count clamped, no offset: fill a set then evict LRU
		plan.push_back(config_row(CFG_WAYS_IN_USE, 5'd8));
		plan.push_back(config_row(CFG_SET_BITS, 5'd7));
		plan.push_back(config_row(CFG_BLOCK_BITS, 5'd0));
		plan.push_back(access_row(32'h0000_0040, MODE_LOAD));
		plan.push_back(access_row(32'h0000_0080, MODE_STORE));
		plan.push_back(access_row(32'h0000_00C0, MODE_MODIFY));
		plan.push_back(access_row(32'h0000_0100, MODE_LOAD));
		plan.push_back(access_row(32'h0000_0140, MODE_RESERVED));
		plan.push_back(access_row(32'h0000_0180, MODE_STORE));
		plan.push_back(access_row(32'h0000_01C0, MODE_LOAD));
		plan.push_back(access_row(32'h0000_0200, MODE_LOAD));
		plan.push_back(access_row(32'h0000_0000, MODE_MODIFY));
		// zero ways acts as one; lines above the count are kept, not searched
		plan.push_back(config_row(CFG_WAYS_IN_USE, 5'd0));
		plan.push_back(access_row(32'h0000_0040, MODE_LOAD));
		plan.push_back(config_row(CFG_WAYS_IN_USE, 5'd15));
		plan.push_back(access_row(32'h0000_0000, MODE_LOAD));
		// offset so wide that the tag vanishes
		plan.push_back(config_row(CFG_BLOCK_BITS, 5'd31));
		plan.push_back(config_row(CFG_SET_BITS, 5'd6));
		plan.push_back(access_row(32'h8000_0000, MODE_MODIFY));
		plan.push_back(access_row(32'h7FFF_FFFF, MODE_STORE));
		plan.push_back(config_row(CFG_BLOCK_BITS, 5'd26));
		plan.push_back(access_row(32'hFC00_0000, MODE_LOAD));
		// single set, tag from the top six bits
		plan.push_back(config_row(CFG_SET_BITS, 5'd0));
		plan.push_back(access_row(32'h0400_0000, MODE_LOAD));
		plan.push_back(access_row(32'hFFFF_FFFF, MODE_LOAD));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].is_cfg) begin
				settle();
				cfg_write(plan[i].idx, plan[i].val);
			end else begin
				issue(plan[i].req, (i + 1 < plan.size()) && !plan[i + 1].is_cfg,
					plan[i].typed, plan[i].want);
			end
		end
		directed_count = requests_sent;

		// random phases, new geometry each time, sender idling varies
		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			cfg_write(CFG_SET_BITS, CFG_DATA_W'(ph_set[p]));
			cfg_write(CFG_WAYS_IN_USE, CFG_DATA_W'(ph_ways[p]));
			cfg_write(CFG_BLOCK_BITS, CFG_DATA_W'(ph_block[p]));
			idle_pct = (p % 3 == 0) ? 38 : ((p % 3 == 1) ? 86 : 0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				req.address = make_address();
				req.mode = 2'($urandom_range(0, 3));
				gap = 0;
				while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
					gap++;
				pause = ($urandom_range(0, 99) == 0);
				issue(req, gap == 0 && !pause && n + 1 < PHASE_ITEMS, 1'b0, '0);
				if (pause)
					settle();
				else
					repeat (gap) @(posedge clk);
			end
		end

		// drain
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Covered %0d directed and %0d random requests, %0d register writes",
			directed_count, requests_sent - directed_count, reg_writes);
		$display("Core reported %0d hits, %0d misses, %0d evictions",
			seen_hits, seen_misses, seen_evicts);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: lru_set_associative_cache_sim_core.f
rtl/core/lsac_pkg.sv
rtl/core/lsac_set_ram.sv
rtl/core/lsac_lookup.sv
rtl/core/lru_set_associative_cache_sim_core.sv
rtl/core/lsac_checker.sv
verif/testbench.sv
